// ===== rtl/core/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Types, constants and helpers shared by the timer table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned SlotCount   = 16;
  localparam int unsigned SlotBits    = $clog2(SlotCount);
  localparam int unsigned TimeBits    = 40;
  localparam int unsigned DelayBits   = 24;
  localparam int unsigned CfgBits     = 20;
  localparam int unsigned WaitBits    = 35;
  localparam int unsigned MaxFires    = 16;
  localparam int unsigned FireBits    = $clog2(MaxFires + 1);
  localparam int unsigned FireIdxBits = $clog2(MaxFires);

  localparam logic [WaitBits-1:0] WaitCap   = 35'd16777215000;
  localparam logic [WaitBits-1:0] WaitEmpty = '1;

  localparam logic [1:0] FuncAdd   = 2'd0;
  localparam logic [1:0] FuncStop  = 2'd1;
  localparam logic [1:0] FuncTick  = 2'd2;
  localparam logic [1:0] FuncQuery = 2'd3;

  localparam logic [1:0] KindAdd  = 2'd0;
  localparam logic [1:0] KindStop = 2'd1;
  localparam logic [1:0] KindFire = 2'd2;
  localparam logic [1:0] KindNone = 2'd3;

  localparam logic CfgTickUs  = 1'b0;
  localparam logic CfgEarlyUs = 1'b1;

  // One slot entry as kept in the slot memory.
  typedef struct packed {
    logic [TimeBits-1:0]  deadline;
    logic [DelayBits-1:0] period_ms;
    logic                 repeats;
  } slot_t;

  // Product of a millisecond count and 1000, as shifts and adds.
  function automatic logic [TimeBits-1:0] ms_to_us(input logic [DelayBits-1:0] ms);
    logic [TimeBits-1:0] m;
    m = TimeBits'(ms);
    return (m << 10) - (m << 4) - (m << 3);
  endfunction

endpackage

// ===== rtl/core/tts_slot_ram.sv =====
// ----------------------------------------------------------------------------
// tts_slot_ram
// Single-port-write, one-read slot memory with a registered read.
// ----------------------------------------------------------------------------
module tts_slot_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [tts_pkg::SlotBits-1:0] waddr_i,
  input  tts_pkg::slot_t               wdata_i,
  input  logic [tts_pkg::SlotBits-1:0] raddr_i,
  output tts_pkg::slot_t               rdata_o
);

  tts_pkg::slot_t mem_q [tts_pkg::SlotCount];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/timer_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// timer_table_scheduler
// Table of timer slots over a wrapping microsecond counter.
// ----------------------------------------------------------------------------
// Every item is handled alone. Add, stop and query take a scan of all slots
// through the slot memory. A tick takes one scan per fired timer, up to
// MaxFires, plus a final scan, then sends its results from a list of fired
// slots, each new result only after the previous one has been taken. The next
// item is taken once the last result has left. Reset empties the table,
// clears time and loads the default registers.
module timer_table_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      func_i,
  input  logic [tts_pkg::DelayBits-1:0]   delay_ms_i,
  input  logic                            repeat_flag_i,
  input  logic [3:0]                      timer_id_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      result_kind_o,
  output logic [3:0]                      slot_id_o,
  output logic                            status_o,
  output logic signed [tts_pkg::WaitBits-1:0] min_wait_us_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [tts_pkg::CfgBits-1:0]     cfg_data_i
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StLast = 5'b00100,
    StAct  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  localparam int unsigned SB = tts_pkg::SlotBits;
  localparam int unsigned TB = tts_pkg::TimeBits;

  state_e state_q, state_d;
  logic [tts_pkg::CfgBits-1:0] tick_us_q, early_us_q;
  logic [TB-1:0] now_q;
  logic [tts_pkg::SlotCount-1:0] valid_q;
  logic [1:0] func_q;
  logic [tts_pkg::DelayBits-1:0] delay_q;
  logic rep_q;
  logic [SB:0] raddr_q;   // one extra bit to count past the last slot
  logic [SB-1:0] rslot_q;
  logic rvld_q;
  logic best_ok_q;
  logic [SB-1:0] best_q;
  logic [TB-1:0] bkey_q, bdiff_q;
  logic [tts_pkg::FireBits-1:0] fires_q;
  // Fired slots wait here until the final wait is known.
  logic [SB-1:0] fired_q [tts_pkg::MaxFires];
  logic [tts_pkg::FireIdxBits-1:0] emit_q;
  logic ov_q;
  logic [1:0] kind_q;
  logic [3:0] oslot_q;
  logic ostat_q, olast_q;
  logic [tts_pkg::WaitBits-1:0] owait_q;

  logic we;
  logic [SB-1:0] waddr, raddr;
  tts_pkg::slot_t wdata, rdata;

  // The best slot is read again in the cycle after the scan for the fire step.
  assign raddr = (state_q == StLast) ? best_q : raddr_q[SB-1:0];

  tts_slot_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [TB-1:0] diff, key;
  logic [tts_pkg::DelayBits-1:0] eff_delay;
  logic free_ok;
  logic [SB-1:0] free_slot;
  logic [tts_pkg::WaitBits-1:0] wait_val;
  logic due, fire_now, fire_out, emit_last;

  assign diff = rdata.deadline - now_q;
  assign key  = diff ^ {1'b1, {(TB-1){1'b0}}};
  assign eff_delay = (rep_q && delay_q == '0) ? tts_pkg::DelayBits'(1) : delay_q;
  assign due = bdiff_q[TB-1] || (bdiff_q < TB'(early_us_q));
  assign fire_now = (state_q == StAct) && (func_q == tts_pkg::FuncTick) && best_ok_q &&
                    due && (fires_q < tts_pkg::FireBits'(tts_pkg::MaxFires));
  assign fire_out = (func_q == tts_pkg::FuncTick) && (fires_q != '0);
  assign emit_last = (tts_pkg::FireBits'(emit_q) + 1'b1) == fires_q;

  always_comb begin
    free_ok = 1'b0;
    free_slot = '0;
    for (int s = tts_pkg::SlotCount - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_ok = 1'b1;
        free_slot = SB'(s);
      end
    end
  end

  always_comb begin
    if (!best_ok_q) begin
      wait_val = tts_pkg::WaitEmpty;
    end else if (bdiff_q[TB-1]) begin
      wait_val = '0;
    end else if (bdiff_q > TB'(tts_pkg::WaitCap)) begin
      wait_val = tts_pkg::WaitCap;
    end else begin
      wait_val = tts_pkg::WaitBits'(bdiff_q);
    end
  end

  // Memory write for add and for re-arming a repeating timer.
  always_comb begin
    we = 1'b0;
    waddr = free_slot;
    wdata.deadline = now_q + tts_pkg::ms_to_us(eff_delay);
    wdata.period_ms = eff_delay;
    wdata.repeats = rep_q;
    if (state_q == StIdle && in_valid_i && in_ready_o && func_i == tts_pkg::FuncAdd) begin
      we = free_ok;
      wdata.deadline = now_q + tts_pkg::ms_to_us(
          (repeat_flag_i && delay_ms_i == '0) ? tts_pkg::DelayBits'(1) : delay_ms_i);
      wdata.period_ms = (repeat_flag_i && delay_ms_i == '0) ?
          tts_pkg::DelayBits'(1) : delay_ms_i;
      wdata.repeats = repeat_flag_i;
    end else if (fire_now) begin
      we = rdata.repeats;
      waddr = best_q;
      wdata.deadline = now_q + tts_pkg::ms_to_us(rdata.period_ms);
      wdata.period_ms = rdata.period_ms;
      wdata.repeats = 1'b1;
    end
  end

  assign in_ready_o  = (state_q == StIdle) && !ov_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign result_kind_o = kind_q;
  assign slot_id_o = oslot_q;
  assign status_o = ostat_q;
  assign min_wait_us_o = owait_q;
  assign last_o = olast_q;

  logic scan_go;   // restart a scan over all slots
  always_comb begin
    state_d = state_q;
    scan_go = 1'b0;
    unique case (state_q)
      StIdle: if (in_valid_i && in_ready_o) begin
        state_d = StScan;
        scan_go = 1'b1;
      end
      StScan: if (raddr_q == (SB + 1)'(tts_pkg::SlotCount)) state_d = StLast;
      StLast: state_d = StAct;
      StAct: begin
        if (fire_now) begin
          state_d = StScan;
          scan_go = 1'b1;
        end else begin
          state_d = StDone;
        end
      end
      StDone: if (!ov_q && (!fire_out || emit_last)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire_now) fired_q[fires_q[tts_pkg::FireIdxBits-1:0]] <= best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tick_us_q <= tts_pkg::CfgBits'(1000);
      early_us_q <= tts_pkg::CfgBits'(1000);
      now_q <= '0;
      valid_q <= '0;
      ov_q <= 1'b0;
      fires_q <= '0;
      emit_q <= '0;
      raddr_q <= '0;
      rvld_q <= 1'b0;
      best_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == tts_pkg::CfgTickUs) tick_us_q <= cfg_data_i;
        else early_us_q <= cfg_data_i;
      end
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      rvld_q <= (state_q == StScan) && (raddr_q < (SB + 1)'(tts_pkg::SlotCount));
      if (state_q == StScan && raddr_q < (SB + 1)'(tts_pkg::SlotCount)) begin
        raddr_q <= raddr_q + 1'b1;
      end
      rslot_q <= raddr_q[SB-1:0];
      // Running earliest-deadline search over the registered reads.
      if (rvld_q && valid_q[rslot_q] && (!best_ok_q || key < bkey_q)) begin
        best_ok_q <= 1'b1;
        best_q <= rslot_q;
        bkey_q <= key;
        bdiff_q <= diff;
      end
      if (scan_go) begin
        raddr_q <= '0;
        best_ok_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: if (in_valid_i && in_ready_o) begin
          func_q <= func_i;
          delay_q <= delay_ms_i;
          rep_q <= repeat_flag_i;
          fires_q <= '0;
          emit_q <= '0;
          unique case (func_i)
            tts_pkg::FuncAdd: begin
              kind_q <= tts_pkg::KindAdd;
              ostat_q <= !free_ok;
              oslot_q <= free_ok ? 4'(free_slot) : 4'd0;
              if (free_ok) valid_q[free_slot] <= 1'b1;
            end
            tts_pkg::FuncStop: begin
              kind_q <= tts_pkg::KindStop;
              oslot_q <= '0;
              if ({1'b0, timer_id_i} < 5'(tts_pkg::SlotCount) &&
                  valid_q[SB'(timer_id_i)]) begin
                valid_q[SB'(timer_id_i)] <= 1'b0;
                ostat_q <= 1'b0;
              end else begin
                ostat_q <= 1'b1;
              end
            end
            tts_pkg::FuncTick: begin
              kind_q <= tts_pkg::KindNone;
              oslot_q <= '0;
              ostat_q <= 1'b0;
              now_q <= now_q + TB'(tick_us_q);
            end
            default: begin
              kind_q <= tts_pkg::KindNone;
              oslot_q <= '0;
              ostat_q <= 1'b0;
            end
          endcase
        end
        StAct: if (fire_now) begin
          if (!rdata.repeats) valid_q[best_q] <= 1'b0;
          fires_q <= fires_q + 1'b1;
        end
        StDone: if (!ov_q) begin
          ov_q <= 1'b1;
          owait_q <= wait_val;
          if (fire_out) begin
            kind_q <= tts_pkg::KindFire;
            oslot_q <= 4'(fired_q[emit_q]);
            olast_q <= emit_last;
            emit_q <= emit_q + 1'b1;
          end else begin
            olast_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timer table scheduler. A short table of directed
// items comes first, followed by a table fill, a mass firing and several random
// phases under different tick and window settings. Every result is compared
// field by field against a predictor that keeps its own slot table and clock.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        status;
    logic [34:0] wait_us;
    logic        last;
  } result_t;

  typedef struct {
    logic [1:0]  func;
    logic [23:0] delay;
    logic        rep;
    logic [3:0]  id;
    bit          typed;
    result_t     want;
  } row_t;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0, repeat_flag_i = 1'b0;
  logic [1:0] func_i = '0;
  logic [23:0] delay_ms_i = '0;
  logic [3:0] timer_id_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_valid_i = 1'b0, cfg_index_i = 1'b0;
  logic [19:0] cfg_data_i = '0;
  logic in_ready_o, out_valid_o, status_o, last_o, cfg_ready_o;
  logic [1:0] result_kind_o;
  logic [3:0] slot_id_o;
  logic signed [34:0] min_wait_us_o;

  always #4 clk_i = ~clk_i;

  timer_table_scheduler u_top (.*);

  // Predictor state.
  logic [39:0] now_us;
  logic        slot_busy [16];
  logic [39:0] slot_due  [16];
  logic [23:0] slot_per  [16];
  logic        slot_rep  [16];
  logic [39:0] tick_len, early_win;

  result_t timer_results_q [$];
  int errors = 0, items_sent = 0, results_seen = 0, fires_seen = 0, full_hits = 0;
  int burst_left = 0, hold_reqs = 0, idle_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [39:0] slack(input int s);
    return slot_due[s] - now_us;
  endfunction

  // Earliest deadline first, ties to the lowest slot; -1 when empty.
  function automatic int earliest_slot();
    int best;
    logic [39:0] bkey, key;
    best = -1;
    bkey = '0;
    for (int s = 0; s < 16; s++) begin
      if (slot_busy[s]) begin
        key = slack(s) ^ (40'd1 << 39);
        if (best < 0 || key < bkey) begin
          best = s;
          bkey = key;
        end
      end
    end
    return best;
  endfunction

  function automatic logic [34:0] min_wait();
    int e;
    logic [39:0] d;
    e = earliest_slot();
    if (e < 0) return '1;
    d = slack(e);
    if (d[39]) return '0;
    if (d > 40'(tts_pkg::WaitCap)) return tts_pkg::WaitCap;
    return d[34:0];
  endfunction

  task automatic predict_op(input logic [1:0] f, input logic [23:0] d, input logic r,
                            input logic [3:0] id);
    result_t outs [$];
    result_t one;
    int fs, e;
    logic [23:0] dd;
    logic [34:0] w;
    logic [39:0] sl;
    one = '0;
    case (f)
      tts_pkg::FuncAdd: begin
        fs = -1;
        for (int s = 15; s >= 0; s--) if (!slot_busy[s]) fs = s;
        one.kind = tts_pkg::KindAdd;
        if (fs < 0) begin
          one.status = 1'b1;
          full_hits++;
        end else begin
          dd = (r && d == 0) ? 24'd1 : d;
          slot_busy[fs] = 1'b1;
          slot_rep[fs] = r;
          slot_per[fs] = dd;
          slot_due[fs] = now_us + 40'(dd) * 40'd1000;
          one.slot = 4'(fs);
        end
        outs.push_back(one);
      end
      tts_pkg::FuncStop: begin
        one.kind = tts_pkg::KindStop;
        one.status = !slot_busy[id];
        slot_busy[id] = 1'b0;
        outs.push_back(one);
      end
      tts_pkg::FuncTick: begin
        now_us = now_us + tick_len;
        while (outs.size() < tts_pkg::MaxFires) begin
          e = earliest_slot();
          if (e < 0) break;
          sl = slack(e);
          if (!(sl[39] || sl < early_win)) break;
          if (slot_rep[e]) slot_due[e] = now_us + 40'(slot_per[e]) * 40'd1000;
          else slot_busy[e] = 1'b0;
          one.kind = tts_pkg::KindFire;
          one.slot = 4'(e);
          outs.push_back(one);
        end
        if (outs.size() == 0) begin
          one.kind = tts_pkg::KindNone;
          outs.push_back(one);
        end
      end
      default: begin
        one.kind = tts_pkg::KindNone;
        outs.push_back(one);
      end
    endcase
    w = min_wait();
    foreach (outs[k]) begin
      outs[k].wait_us = w;
      outs[k].last = (k == outs.size() - 1);
      timer_results_q.push_back(outs[k]);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  task automatic send_op(input logic [1:0] f, input logic [23:0] d, input logic r,
                         input logic [3:0] id, input bit typed, input result_t want);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i = f;
    delay_ms_i = d;
    repeat_flag_i = r;
    timer_id_i = id;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_op(f, d, r, id);
    if (typed) timer_results_q[$] = want;
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (timer_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tts_pkg::CfgTickUs) tick_len = 40'(val);
    else early_win = 40'(val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_op();
    logic [1:0] f;
    logic [23:0] d;
    logic [3:0] id;
    int pick, busy [$];
    pick = $urandom_range(0, 99);
    f = pick < 35 ? tts_pkg::FuncAdd : pick < 70 ? tts_pkg::FuncTick :
        pick < 90 ? tts_pkg::FuncStop : tts_pkg::FuncQuery;
    pick = $urandom_range(0, 99);
    if (pick < 40) d = 24'($urandom_range(0, 5));
    else if (pick < 75) d = 24'($urandom_range(0, 60));
    else if (pick < 85) d = 24'($urandom_range(0, 2000));
    else if (pick < 95) d = 24'($urandom);
    else d = pick[0] ? 24'hFFFFFF : 24'd0;
    for (int s = 0; s < 16; s++) if (slot_busy[s]) busy.push_back(s);
    id = 4'($urandom);
    if (busy.size() > 0 && $urandom_range(0, 9) < 7)
      id = 4'(busy[$urandom_range(0, busy.size() - 1)]);
    send_op(f, d, 1'($urandom), id, 1'b0, '0);
  endtask

  function automatic row_t mk(input logic [1:0] f, input logic [23:0] d, input logic r,
                              input logic [3:0] id, input bit typed, input result_t want);
    row_t x;
    x.func = f;
    x.delay = d;
    x.rep = r;
    x.id = id;
    x.typed = typed;
    x.want = want;
    return x;
  endfunction

  // Receiver: changes its stall pattern in phases; long hold-offs on request.
  always @(negedge clk_i) begin
    static int phase_ctr = 0, mode = 0, hold_left = 0, hold_done = 0;
    if (phase_ctr == 0) mode = $urandom_range(0, 3);
    phase_ctr = (phase_ctr + 1) % 50;
    if (hold_done != hold_reqs) begin
      hold_left = 400;
      hold_done = hold_reqs;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= phase_ctr[3];
      endcase
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (result_kind_o == tts_pkg::KindFire) fires_seen++;
      if (timer_results_q.size() == 0) begin
        report("unexpected result", longint'(result_kind_o), -1);
      end else begin
        exp_r = timer_results_q.pop_front();
        if (result_kind_o != exp_r.kind)
          report("result_kind", longint'(result_kind_o), longint'(exp_r.kind));
        if (slot_id_o != exp_r.slot)
          report("slot_id", longint'(slot_id_o), longint'(exp_r.slot));
        if (status_o != exp_r.status)
          report("status", longint'(status_o), longint'(exp_r.status));
        if (min_wait_us_o != $signed(exp_r.wait_us))
          report("min_wait_us", longint'(min_wait_us_o), longint'($signed(exp_r.wait_us)));
        if (last_o != exp_r.last)
          report("last", longint'(last_o), longint'(exp_r.last));
      end
    end
  end

  // Watchdog on cycles with no accepted item on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t rows [$];
    result_t r;
    logic [19:0] cfg_sets [5][2];
    now_us = '0;
    tick_len = 40'd1000;
    early_win = 40'd1000;
    for (int s = 0; s < 16; s++) begin
      slot_busy[s] = 1'b0;
      slot_due[s] = '0;
      slot_per[s] = '0;
      slot_rep[s] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table answers, then a one-shot zero delay, a maximal periodic
    // delay and a periodic zero delay that must behave as one millisecond.
    r = '{kind: tts_pkg::KindNone, slot: 0, status: 0, wait_us: '1, last: 1};
    rows.push_back(mk(tts_pkg::FuncQuery, 24'hFFFFFF, 1, 4'hF, 1, r));
    r = '{kind: tts_pkg::KindStop, slot: 0, status: 1, wait_us: '1, last: 1};
    rows.push_back(mk(tts_pkg::FuncStop, 0, 0, 5, 1, r));
    r = '{kind: tts_pkg::KindNone, slot: 0, status: 0, wait_us: '1, last: 1};
    rows.push_back(mk(tts_pkg::FuncTick, 0, 0, 0, 1, r));
    r = '{kind: tts_pkg::KindAdd, slot: 0, status: 0, wait_us: 0, last: 1};
    rows.push_back(mk(tts_pkg::FuncAdd, 0, 0, 4'hF, 1, r));
    rows.push_back(mk(tts_pkg::FuncAdd, 24'hFFFFFF, 1, 4'hF, 0, '0));
    rows.push_back(mk(tts_pkg::FuncAdd, 0, 1, 0, 0, '0));
    rows.push_back(mk(tts_pkg::FuncQuery, 0, 0, 0, 0, '0));
    rows.push_back(mk(tts_pkg::FuncTick, 0, 0, 0, 0, '0));
    rows.push_back(mk(tts_pkg::FuncTick, 0, 0, 0, 0, '0));
    rows.push_back(mk(tts_pkg::FuncStop, 0, 0, 15, 0, '0));
    rows.push_back(mk(tts_pkg::FuncStop, 0, 0, 1, 0, '0));
    rows.push_back(mk(tts_pkg::FuncAdd, 24'h800000, 0, 0, 0, '0));
    rows.push_back(mk(tts_pkg::FuncAdd, 24'h7FFFFF, 1, 0, 0, '0));
    rows.push_back(mk(tts_pkg::FuncTick, 0, 0, 0, 0, '0));
    rows.push_back(mk(tts_pkg::FuncQuery, 0, 0, 0, 0, '0));
    rows.push_back(mk(tts_pkg::FuncStop, 0, 0, 2, 0, '0));
    rows.push_back(mk(tts_pkg::FuncStop, 0, 0, 0, 0, '0));
    foreach (rows[i])
      send_op(rows[i].func, rows[i].delay, rows[i].rep, rows[i].id, rows[i].typed, rows[i].want);

    // Fill the table past full, then fire everything in one wide tick.
    for (int i = 0; i < 18; i++)
      send_op(tts_pkg::FuncAdd, 24'($urandom_range(0, 2)), i[0], 0, 0, '0);
    drain();
    write_reg(tts_pkg::CfgEarlyUs, 20'd1000000);
    write_reg(tts_pkg::CfgTickUs, 20'd1000000);
    send_op(tts_pkg::FuncTick, 0, 0, 0, 0, '0);
    send_op(tts_pkg::FuncTick, 0, 0, 0, 0, '0);
    for (int i = 0; i < 16; i++) send_op(tts_pkg::FuncStop, 0, 0, 4'(i), 0, '0);
    drain();

    cfg_sets = '{'{20'd1000, 20'd1000}, '{20'd1, 20'd0}, '{20'd1000000, 20'd1000000},
                 '{20'd250, 20'd5000}, '{20'd3000, 20'd0}};
    for (int p = 0; p < 5; p++) begin
      write_reg(tts_pkg::CfgTickUs, cfg_sets[p][0]);
      write_reg(tts_pkg::CfgEarlyUs, cfg_sets[p][1]);
      // The receiver holds off long while the sender keeps offering items.
      if (p == 2) hold_reqs++;
      for (int i = 0; i < 70; i++) random_op();
      drain();
    end

    $display("Covered %0d items and %0d results, %0d timer firings, %0d full-table adds.",
             items_sent, results_seen, fires_seen, full_hits);
    $display("Settings went through tick and window extremes with burst and stall traffic.");
    if (errors == 0 && timer_results_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/tts_pkg.sv
rtl/core/tts_slot_ram.sv
rtl/core/timer_table_scheduler.sv
test/testbench.sv
